### hdl/dcfr_pkg.sv
// ----------------------------------------------------------------------------
// dcfr_pkg
// Shared types and constants of the delimited command frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartChar = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEndChar   = 8'd1;

  localparam logic [ByteW-1:0] StartCharRst = 8'd35;
  localparam logic [ByteW-1:0] EndCharRst   = 8'd33;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TAKE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    TAKE_NONE,
    TAKE_EMPTY,
    TAKE_STREAM
  } take_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_FETCH,
    ST_STREAM
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic byte_en;
    logic take_en;
    logic rd_en;
    logic load_reply;
    logic load_char;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    take_kind_e take_kind;
    logic       rem_one;
    logic       slot_free;
  } status_t;

  typedef struct packed {
    logic             has_command;
    logic             byte_valid;
    logic [ByteW-1:0] cmd_byte;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

### hdl/dcfr_if.sv
// ----------------------------------------------------------------------------
// dcfr_if
// Valid/ready channels of the frame receiver: input items, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcfr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [dcfr_pkg::ByteW-1:0]  rx_byte;
  logic [dcfr_pkg::ByteW-1:0]  out_limit;

  modport source (output valid, output opcode, output rx_byte, output out_limit,
                  input ready);
  modport sink   (input valid, input opcode, input rx_byte, input out_limit,
                  output ready);
endinterface

interface dcfr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        has_command;
  logic                        byte_valid;
  logic [dcfr_pkg::ByteW-1:0]  cmd_byte;
  logic                        last;

  modport source (output valid, output has_command, output byte_valid,
                  output cmd_byte, output last, input ready);
  modport sink   (input valid, input has_command, input byte_valid,
                  input cmd_byte, input last, output ready);
endinterface

interface dcfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dcfr_pkg::CfgIdxW-1:0] index;
  logic [dcfr_pkg::ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/dcfr_ctrl.sv
// ----------------------------------------------------------------------------
// dcfr_ctrl
// Controller: accepts items and sequences the read-out of a held command.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              opcode_i,
  output logic                   in_ready_o,
  input  wire dcfr_pkg::status_t status_i,
  output dcfr_pkg::cmd_t         cmd_o
);

  dcfr_pkg::state_e state_q, state_d;
  logic             accept;
  logic             is_take;

  assign in_ready_o = (state_q == dcfr_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign is_take    = (dcfr_pkg::op_e'(opcode_i) == dcfr_pkg::OP_TAKE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcfr_pkg::ST_IDLE: begin
        if (accept && is_take) begin
          if (status_i.take_kind == dcfr_pkg::TAKE_STREAM) begin
            state_d = dcfr_pkg::ST_FETCH;
          end else begin
            state_d = dcfr_pkg::ST_REPLY;
          end
        end
      end
      dcfr_pkg::ST_REPLY: begin
        if (status_i.slot_free) begin
          state_d = dcfr_pkg::ST_IDLE;
        end
      end
      dcfr_pkg::ST_FETCH: begin
        state_d = dcfr_pkg::ST_STREAM;
      end
      dcfr_pkg::ST_STREAM: begin
        if (status_i.slot_free && status_i.rem_one) begin
          state_d = dcfr_pkg::ST_IDLE;
        end
      end
      default: state_d = dcfr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      dcfr_pkg::ST_IDLE: begin
        cmd_o.byte_en = accept & ~is_take;
        cmd_o.take_en = accept & is_take;
      end
      dcfr_pkg::ST_REPLY: begin
        cmd_o.load_reply = status_i.slot_free;
      end
      dcfr_pkg::ST_FETCH: begin
        cmd_o.rd_en = 1'b1;
      end
      dcfr_pkg::ST_STREAM: begin
        cmd_o.load_char = status_i.slot_free;
        // prefetch the next character while this one moves out
        cmd_o.rd_en     = status_i.slot_free & ~status_i.rem_one;
      end
      default: cmd_o = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_take_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_en |=> state_q != dcfr_pkg::ST_IDLE)
    else $error("take did not start a read-out");
  a_fetch_then_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dcfr_pkg::ST_FETCH |=> state_q == dcfr_pkg::ST_STREAM)
    else $error("fetch not followed by stream");
  a_load_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_char && cmd_o.load_reply))
    else $error("two results loaded at once");
`endif

endmodule

`default_nettype wire

### hdl/dcfr_datapath.sv
// ----------------------------------------------------------------------------
// dcfr_datapath
// Frame store, frame assembly, held command and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfr_datapath #(
  parameter int unsigned FrameBufSize = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dcfr_pkg::cmd_t               cmd_i,
  output dcfr_pkg::status_t                 status_o,
  input  wire logic [dcfr_pkg::ByteW-1:0]   rx_byte_i,
  input  wire logic [dcfr_pkg::ByteW-1:0]   out_limit_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [dcfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dcfr_pkg::ByteW-1:0]   cfg_data_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output dcfr_pkg::res_t                    result_o
);

  localparam int unsigned CntW = $clog2(FrameBufSize);
  localparam logic [CntW-1:0] FillMax = CntW'(FrameBufSize - 1);

  typedef logic [dcfr_pkg::ByteW-1:0] byte_t;

  byte_t                start_char_q, end_char_q;
  byte_t                mem [FrameBufSize];
  byte_t                rd_data_q;
  byte_t                first_q, first_d;
  byte_t                last_q, last_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic                 in_frame_q, in_frame_d;
  logic                 cmd_ready_q, cmd_ready_d;
  logic [CntW-1:0]      cmd_len_q, cmd_len_d;
  logic [CntW-1:0]      rem_q;
  logic [CntW-1:0]      rd_idx_q;
  logic [CntW-1:0]      take_len;
  dcfr_pkg::take_kind_e take_kind;
  logic                 reply_has_q;
  logic                 out_valid_q;
  dcfr_pkg::res_t       res_q;
  logic                 wr_en;
  logic [CntW-1:0]      wr_addr;
  logic                 has_room;
  logic [CntW-1:0]      fill_end;
  byte_t                last_end;
  logic                 slot_free;

  // ---- configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= dcfr_pkg::StartCharRst;
      end_char_q   <= dcfr_pkg::EndCharRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dcfr_pkg::CfgStartChar: start_char_q <= cfg_data_i;
        dcfr_pkg::CfgEndChar:   end_char_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- frame assembly
  assign has_room = (fill_q < FillMax);
  assign fill_end = has_room ? fill_q + 1'b1 : fill_q;
  assign last_end = has_room ? rx_byte_i : last_q;

  always_comb begin
    fill_d      = fill_q;
    in_frame_d  = in_frame_q;
    cmd_ready_d = cmd_ready_q;
    cmd_len_d   = cmd_len_q;
    first_d     = first_q;
    last_d      = last_q;
    wr_en       = 1'b0;
    wr_addr     = fill_q;
    if (cmd_i.byte_en && !cmd_ready_q) begin
      if (!in_frame_q) begin
        if (rx_byte_i == start_char_q) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          first_d    = rx_byte_i;
          last_d     = rx_byte_i;
          fill_d     = CntW'(1);
          in_frame_d = 1'b1;
        end
      end else if (rx_byte_i == end_char_q) begin
        wr_en  = has_room;
        last_d = last_end;
        if (fill_end >= CntW'(2) && first_q == start_char_q && last_end == end_char_q) begin
          cmd_ready_d = 1'b1;
          cmd_len_d   = fill_end;
        end
        fill_d     = '0;
        in_frame_d = 1'b0;
      end else if (rx_byte_i == start_char_q) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        first_d = rx_byte_i;
        last_d  = rx_byte_i;
        fill_d  = CntW'(1);
      end else if (has_room) begin
        wr_en  = 1'b1;
        last_d = rx_byte_i;
        fill_d = fill_q + 1'b1;
      end else begin
        fill_d     = '0;
        in_frame_d = 1'b0;
      end
    end
    // a take with a command and a nonzero limit releases the command
    if (cmd_i.take_en && take_kind != dcfr_pkg::TAKE_NONE) begin
      cmd_ready_d = 1'b0;
      cmd_len_d   = '0;
    end
  end

  // ---- take decision
  always_comb begin
    if (dcfr_pkg::ByteW'(cmd_len_q) >= out_limit_i) begin
      take_len = CntW'(out_limit_i - 1'b1);
    end else begin
      take_len = cmd_len_q;
    end
    if (!cmd_ready_q || out_limit_i == '0) begin
      take_kind = dcfr_pkg::TAKE_NONE;
    end else if (take_len == '0) begin
      take_kind = dcfr_pkg::TAKE_EMPTY;
    end else begin
      take_kind = dcfr_pkg::TAKE_STREAM;
    end
  end

  assign slot_free = ~out_valid_q | out_ready_i;
  assign status_o  = '{take_kind: take_kind,
                       rem_one:   (rem_q == CntW'(1)),
                       slot_free: slot_free};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      in_frame_q  <= 1'b0;
      cmd_ready_q <= 1'b0;
      cmd_len_q   <= '0;
      rem_q       <= '0;
      rd_idx_q    <= '0;
      reply_has_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      in_frame_q  <= in_frame_d;
      cmd_ready_q <= cmd_ready_d;
      cmd_len_q   <= cmd_len_d;
      if (cmd_i.take_en) begin
        rem_q       <= take_len;
        rd_idx_q    <= '0;
        reply_has_q <= (take_kind == dcfr_pkg::TAKE_EMPTY);
      end else begin
        if (cmd_i.load_char) begin
          rem_q <= rem_q - 1'b1;
        end
        if (cmd_i.rd_en) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      out_valid_q <= cmd_i.load_char | cmd_i.load_reply | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
  end

  // ---- frame store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  // ---- result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_reply) begin
      res_q.has_command <= reply_has_q;
      res_q.byte_valid  <= 1'b0;
      res_q.cmd_byte    <= '0;
      res_q.last        <= 1'b1;
    end else if (cmd_i.load_char) begin
      res_q.has_command <= 1'b1;
      res_q.byte_valid  <= 1'b1;
      res_q.cmd_byte    <= rd_data_q;
      res_q.last        <= status_o.rem_one;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill index beyond frame store");
  a_idle_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> fill_q == '0)
    else $error("fill index nonzero outside a frame");
  a_held_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_q |-> cmd_len_q >= CntW'(2))
    else $error("held command shorter than two");
  a_publish_from_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_ready_q) |-> $past(in_frame_q))
    else $error("command published outside a frame");
`endif

endmodule

`default_nettype wire

### hdl/delimited_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// delimited_command_frame_receiver
// Assembles start/end delimited text frames and streams out a held command.
//
//   port      role    payload
//   in_chan   sink    opcode, rx_byte, out_limit
//   out_chan  source  has_command, byte_valid, cmd_byte, last
//   cfg_chan  sink    index, data (0 start_char, 1 end_char)
//
// A received byte leaves the controller idle; a new item is accepted the next cycle.
// A take with a one-result reply passes REPLY; a take of n characters reads the
// frame store in FETCH, then STREAM sends one character per cycle unless stalled.
// Stalls on out_chan hold the read-out; one finished result waits in the
// output register while the next input is accepted. Config is always ready.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_command_frame_receiver #(
  parameter int unsigned FrameBufSize = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dcfr_in_if.sink    in_chan,
  dcfr_out_if.source out_chan,
  dcfr_cfg_if.sink   cfg_chan
);

  dcfr_pkg::cmd_t    cmd;
  dcfr_pkg::status_t status;
  dcfr_pkg::res_t    result;

  assign cfg_chan.ready = 1'b1;

  dcfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .opcode_i   (in_chan.opcode),
    .in_ready_o (in_chan.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dcfr_datapath #(
    .FrameBufSize (FrameBufSize)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .rx_byte_i   (in_chan.rx_byte),
    .out_limit_i (in_chan.out_limit),
    .cfg_valid_i (cfg_chan.valid),
    .cfg_index_i (cfg_chan.index),
    .cfg_data_i  (cfg_chan.data),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .result_o    (result)
  );

  assign out_chan.has_command = result.has_command;
  assign out_chan.byte_valid  = result.byte_valid;
  assign out_chan.cmd_byte    = result.cmd_byte;
  assign out_chan.last        = result.last;

endmodule

`default_nettype wire

### bench/tb_delimited_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_delimited_command_frame_receiver
// Self-checking bench for the delimited command frame receiver. A directed
// table covers the corner cases at the reset delimiters. Random frames,
// noise and takes follow under several delimiter settings. Every reply is
// checked field by field against a cycle-free model of frame assembly and
// command read-out. Both handshake sides idle at random.
// ----------------------------------------------------------------------------

module tb_delimited_command_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteW         = dcfr_pkg::ByteW;
  localparam int unsigned CfgIdxW       = dcfr_pkg::CfgIdxW;
  localparam int unsigned FrameBufSize  = 64;
  localparam int unsigned MaxCmdLen     = FrameBufSize - 1;
  localparam int unsigned IdlePct       = 18;
  localparam int unsigned QuietSpan     = 700;
  localparam int unsigned IdleWindow    = 3000;
  localparam int unsigned ItemsPerPhase = 61;
  localparam int unsigned LimitCycles   = 400000;
  localparam int unsigned MaxPrinted    = 40;
  localparam logic [CfgIdxW-1:0] CfgSpare = 8'd2;  // first index with no register

  localparam dcfr_pkg::res_t NoCmd     = '{has_command: 1'b0, byte_valid: 1'b0,
                                           cmd_byte: '0, last: 1'b1};
  localparam dcfr_pkg::res_t EmptyTake = '{has_command: 1'b1, byte_valid: 1'b0,
                                           cmd_byte: '0, last: 1'b1};

  typedef struct {
    dcfr_pkg::op_e    op;
    logic [ByteW-1:0] rx;
    logic [ByteW-1:0] lim;
    bit               typed;
    dcfr_pkg::res_t   want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcfr_in_if  in_chan ();
  dcfr_out_if out_chan ();
  dcfr_cfg_if cfg_chan ();

  delimited_command_frame_receiver #(
    .FrameBufSize(FrameBufSize)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic [ByteW-1:0] start_ch;
  logic [ByteW-1:0] end_ch;
  logic [ByteW-1:0] frame_mem [FrameBufSize];
  int unsigned      fill_idx;
  int unsigned      cmd_len;
  bit               in_frm;
  bit               cmd_held;

  dcfr_pkg::res_t due_replies [$];
  row_t           dir_tab [25];
  int unsigned    err_cnt;
  int unsigned    cyc_cnt;
  int unsigned    live_items;

  function automatic void frame_append(logic [ByteW-1:0] b);
    if (fill_idx < FrameBufSize) begin
      frame_mem[fill_idx] = b;
      fill_idx++;
    end
  endfunction

  function automatic void frame_close();
    fill_idx = 0;
    in_frm   = 1'b0;
  endfunction

  // returns 0 when the byte leaves the state untouched
  function automatic bit rx_assemble(logic [ByteW-1:0] d);
    if (cmd_held) return 1'b0;
    if (!in_frm) begin
      if (d != start_ch) return 1'b0;
      fill_idx = 0;
      frame_append(d);
      in_frm = 1'b1;
      return 1'b1;
    end
    // end char is tested first, so it wins when both delimiters are equal
    if (d == end_ch) begin
      if (fill_idx < MaxCmdLen) frame_append(d);
      if (fill_idx >= 2 && frame_mem[0] == start_ch && frame_mem[fill_idx-1] == end_ch) begin
        cmd_len  = (fill_idx > MaxCmdLen) ? MaxCmdLen : fill_idx;
        cmd_held = 1'b1;
      end
      frame_close();
    end else if (d == start_ch) begin
      fill_idx = 0;
      frame_append(d);
    end else if (fill_idx < MaxCmdLen) begin
      frame_append(d);
    end else begin
      frame_close();
    end
    return 1'b1;
  endfunction

  function automatic void take_reply(logic [ByteW-1:0] lim);
    int unsigned n;
    if (!cmd_held || lim == 0) begin
      due_replies.push_back(NoCmd);
      return;
    end
    n = cmd_len;
    if (n >= lim) n = lim - 1;
    cmd_held = 1'b0;
    cmd_len  = 0;
    if (n == 0) begin
      due_replies.push_back(EmptyTake);
      return;
    end
    for (int i = 0; i < n; i++) begin
      due_replies.push_back('{has_command: 1'b1, byte_valid: 1'b1, cmd_byte: frame_mem[i],
                              last: (i == n - 1)});
    end
  endfunction

  function automatic bit side_idles();
    return (cyc_cnt % IdleWindow >= QuietSpan) && ($urandom_range(99) < IdlePct);
  endfunction

  task automatic flag_mismatch(string what);
    if (err_cnt < MaxPrinted) $display("mismatch at cycle %0d: %s", cyc_cnt, what);
    err_cnt++;
  endtask

  task automatic send_item(input dcfr_pkg::op_e op, input logic [ByteW-1:0] rx,
                           input logic [ByteW-1:0] lim, input bit typed,
                           input dcfr_pkg::res_t want, output bit took);
    int unsigned n;
    while (side_idles()) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid     <= 1'b1;
    in_chan.opcode    <= op;
    in_chan.rx_byte   <= rx;
    in_chan.out_limit <= lim;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    n    = due_replies.size();
    took = 1'b1;
    if (op == dcfr_pkg::OP_BYTE) took = rx_assemble(rx);
    else take_reply(lim);
    if (typed) begin
      while (due_replies.size() > n) void'(due_replies.pop_back());
      due_replies.push_back(want);
    end
  endtask

  task automatic rnd_byte(logic [ByteW-1:0] b);
    bit took;
    send_item(dcfr_pkg::OP_BYTE, b, ByteW'($urandom_range(255)), 1'b0, NoCmd, took);
    live_items++;
  endtask

  task automatic rnd_take(logic [ByteW-1:0] lim);
    bit took;
    send_item(dcfr_pkg::OP_TAKE, ByteW'($urandom_range(255)), lim, 1'b0, NoCmd, took);
    live_items++;
  endtask

  function automatic logic [ByteW-1:0] body_byte();
    logic [ByteW-1:0] b;
    bit               keep;
    keep = $urandom_range(99) < 15;
    do b = ByteW'($urandom_range(255));
    while (!keep && (b == start_ch || b == end_ch));
    return b;
  endfunction

  function automatic logic [ByteW-1:0] pick_limit(int unsigned len);
    case ($urandom_range(7))
      0: return '0;
      1: return 8'd1;
      2: return 8'd2;
      3: return ByteW'(len);
      4: return ByteW'(len + 1);
      5: return 8'hFF;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  task automatic random_burst();
    int unsigned body;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // mostly short frames, now and then one long enough to overflow
      body = ($urandom_range(99) < 8) ? $urandom_range(66, 58) : $urandom_range(8);
      rnd_byte(start_ch);
      repeat (body) rnd_byte(body_byte());
      if ($urandom_range(99) < 90) rnd_byte(end_ch);
      if ($urandom_range(99) < 80) rnd_take(pick_limit(body + 2));
    end else if (kind < 85) begin
      repeat ($urandom_range(4, 1)) rnd_byte(ByteW'($urandom_range(255)));
    end else begin
      rnd_take(ByteW'($urandom_range(255)));
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk_i);
    while (!cfg_chan.ready) @(posedge clk_i);
    if (idx == dcfr_pkg::CfgStartChar) start_ch = val;
    else if (idx == dcfr_pkg::CfgEndChar) end_ch = val;
  endtask

  // wait until every reply is back and the block has gone quiet
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [ByteW-1:0] s, logic [ByteW-1:0] e, bit with_table);
    bit took;
    settle();
    write_reg(dcfr_pkg::CfgStartChar, s);
    write_reg(dcfr_pkg::CfgEndChar, e);
    write_reg(CfgIdxW'($urandom_range(255, CfgSpare)), ByteW'($urandom_range(255)));
    cfg_chan.valid <= 1'b0;
    if (with_table) begin
      foreach (dir_tab[k]) begin
        send_item(dir_tab[k].op, dir_tab[k].rx, dir_tab[k].lim, dir_tab[k].typed,
                  dir_tab[k].want, took);
      end
    end
    live_items = 0;
    while (live_items < ItemsPerPhase) random_burst();
  endtask

  always @(posedge clk_i) begin : result_check
    dcfr_pkg::res_t got_r;
    dcfr_pkg::res_t want_r;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      got_r = '{has_command: out_chan.has_command, byte_valid: out_chan.byte_valid,
                cmd_byte: out_chan.cmd_byte, last: out_chan.last};
      if (due_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected reply %p", got_r));
      end else begin
        want_r = due_replies.pop_front();
        if (got_r.has_command !== want_r.has_command || got_r.byte_valid !== want_r.byte_valid
            || got_r.cmd_byte !== want_r.cmd_byte || got_r.last !== want_r.last) begin
          flag_mismatch($sformatf("got %p want %p", got_r, want_r));
        end
      end
    end
    out_chan.ready <= rst_ni && !side_idles();
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.opcode     = dcfr_pkg::OP_BYTE;
    in_chan.rx_byte    = '0;
    in_chan.out_limit  = '0;
    out_chan.ready     = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = '0;
    cfg_chan.data      = '0;
    err_cnt            = 0;
    cyc_cnt            = 0;
    start_ch           = dcfr_pkg::StartCharRst;
    end_ch             = dcfr_pkg::EndCharRst;
    fill_idx           = 0;
    cmd_len            = 0;
    in_frm             = 1'b0;
    cmd_held           = 1'b0;

    // typed replies are the fixed ones: nothing held, zero limit, limit of one
    dir_tab = '{
      '{dcfr_pkg::OP_TAKE, 8'h00,                  8'd5,  1'b1, NoCmd},
      '{dcfr_pkg::OP_BYTE, 8'h41,                  8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::StartCharRst, 8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, 8'h41,                  8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::EndCharRst,   8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::StartCharRst, 8'hFF, 1'b0, NoCmd},
      '{dcfr_pkg::OP_TAKE, 8'hFF,                  8'd0,  1'b1, NoCmd},
      '{dcfr_pkg::OP_TAKE, 8'h00,                  8'd2,  1'b0, NoCmd},
      '{dcfr_pkg::OP_TAKE, 8'h00,                  8'hFF, 1'b1, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::StartCharRst, 8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, 8'hFF,                  8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, 8'h00,                  8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::EndCharRst,   8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_TAKE, 8'h00,                  8'd1,  1'b1, EmptyTake},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::StartCharRst, 8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::EndCharRst,   8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_TAKE, 8'h00,                  8'hFF, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::StartCharRst, 8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, 8'h55,                  8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::StartCharRst, 8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, 8'hAA,                  8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::EndCharRst,   8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_TAKE, 8'h00,                  8'd3,  1'b0, NoCmd},
      '{dcfr_pkg::OP_BYTE, dcfr_pkg::EndCharRst,   8'h00, 1'b0, NoCmd},
      '{dcfr_pkg::OP_TAKE, 8'hFF,                  8'h80, 1'b1, NoCmd}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_phase(dcfr_pkg::StartCharRst, dcfr_pkg::EndCharRst, 1'b1);
    run_phase(8'h00, 8'hFF, 1'b0);
    run_phase(8'hFF, 8'h00, 1'b0);
    // equal delimiters: the end char takes precedence inside a frame
    run_phase(8'h7E, 8'h7E, 1'b0);
    run_phase(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)), 1'b0);
    settle();

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
